[src/msf_pkg.sv]
// Shared constants, record layouts and controller/datapath interface types.
package msf_pkg;

   localparam int VERTEX_MAX = 64;
   localparam int EDGE_MAX   = 256;

   localparam int VTX_W    = 6;
   localparam int WEIGHT_W = 16;
   localparam int VC_W     = 7;
   localparam int PAR_AW   = (VERTEX_MAX > 1) ? $clog2(VERTEX_MAX) : 1;
   localparam int EDGE_W   = (EDGE_MAX > 1) ? $clog2(EDGE_MAX) : 1;
   localparam int CNT_W    = EDGE_W + 1;
   localparam int EREC_W   = 2 * VTX_W + WEIGHT_W;
   localparam int KEY_W    = WEIGHT_W + EDGE_W;

   localparam logic [VC_W-1:0] VC_RESET = VC_W'(64);

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic pick;
      logic find_issue;
      logic find_check;
      logic link;
      logic hold_new;
      logic push_held;
      logic push_final;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_fire;
      logic req_last;
      logic stop;
      logic scan_end;
      logic have_best;
      logic out_of_range;
      logic fnd_root;
      logic fnd_phase;
      logic roots_equal;
      logic held_valid;
      logic out_free;
   } ctrl_sts_type;

endpackage

[src/msf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module msf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/msf_ctrl.sv]
// Controller state machine sequencing load, selection scan, find and union.
module msf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  msf_pkg::ctrl_sts_type sts,
   output msf_pkg::ctrl_cmd_type cmd
);

   localparam logic [3:0] ST_LOAD  = 4'd0;
   localparam logic [3:0] ST_NEXT  = 4'd1;
   localparam logic [3:0] ST_SCAN  = 4'd2;
   localparam logic [3:0] ST_PICK  = 4'd3;
   localparam logic [3:0] ST_ISSUE = 4'd4;
   localparam logic [3:0] ST_CHECK = 4'd5;
   localparam logic [3:0] ST_JOIN  = 4'd6;
   localparam logic [3:0] ST_HOLD  = 4'd7;
   localparam logic [3:0] ST_FINAL = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (sts.req_fire && sts.req_last) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (sts.stop) begin
               state_in = ST_FINAL;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_end) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (!sts.have_best) begin
               state_in = ST_FINAL;
            end else begin
               cmd.pick = 1'b1;
               state_in = sts.out_of_range ? ST_NEXT : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.find_issue = 1'b1;
            state_in       = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.find_check = 1'b1;
            if (sts.fnd_root && sts.fnd_phase) begin
               state_in = ST_JOIN;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_JOIN: begin
            if (sts.roots_equal) begin
               state_in = ST_NEXT;
            end else begin
               cmd.link = 1'b1;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!sts.held_valid) begin
               cmd.hold_new = 1'b1;
               state_in     = ST_NEXT;
            end else if (sts.out_free) begin
               cmd.push_held = 1'b1;
               state_in      = ST_NEXT;
            end
         end
         ST_FINAL: begin
            if (sts.out_free) begin
               cmd.push_final = 1'b1;
               state_in       = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/msf_datapath.sv]
// Datapath: edge store, selection scan, union-find parent store and result registers.
module msf_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  msf_pkg::ctrl_cmd_type         cmd,
   output msf_pkg::ctrl_sts_type         sts,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [msf_pkg::VC_W-1:0]      csr_vertex_count,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [msf_pkg::VTX_W-1:0]     req_src_vertex,
   input  logic [msf_pkg::VTX_W-1:0]     req_dest_vertex,
   input  logic signed [msf_pkg::WEIGHT_W-1:0] req_edge_weight,
   input  logic                          req_last_edge,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [msf_pkg::VTX_W-1:0]     rsp_tree_src,
   output logic [msf_pkg::VTX_W-1:0]     rsp_tree_dest,
   output logic signed [msf_pkg::WEIGHT_W-1:0] rsp_tree_weight,
   output logic                          rsp_edge_valid,
   output logic                          rsp_last_result,
   output logic                          rsp_store_overflow
);

   localparam int VW = msf_pkg::VTX_W;
   localparam int WW = msf_pkg::WEIGHT_W;
   localparam int EW = msf_pkg::EDGE_W;
   localparam int CW = msf_pkg::CNT_W;
   localparam int KW = msf_pkg::KEY_W;
   localparam int AW = msf_pkg::PAR_AW;
   localparam int NW = msf_pkg::VC_W;

   logic [NW-1:0] vc_ff;
   logic [CW-1:0] cnt_ff, sidx_ff;
   logic          ovf_ff;
   logic [VW-1:0] acc_ff;
   logic          rdp_ff;
   logic [EW-1:0] rdi_ff;
   logic          hp_ff, hb_ff;
   logic [KW-1:0] pkey_ff, bkey_ff;
   logic [VW-1:0] bsrc_ff, bdst_ff;
   logic [WW-1:0] bw_ff;
   logic [VW-1:0] v_ff, ra_ff, rb_ff;
   logic          ph_ff, pv_ff;
   logic [msf_pkg::VERTEX_MAX-1:0] vld_ff;
   logic          held_ff;
   logic [VW-1:0] hsrc_ff, hdst_ff;
   logic [WW-1:0] hw_ff;
   logic          ov_ff, oev_ff, olast_ff, oovf_ff;
   logic [VW-1:0] osrc_ff, odst_ff;
   logic [WW-1:0] ow_ff;

   logic                     req_fire, rsp_fire, store_full;
   logic [msf_pkg::EREC_W-1:0] erec_rd;
   logic [VW-1:0]            r_src, r_dst, prnt_rd, p_val;
   logic [WW-1:0]            r_w;
   logic [KW-1:0]            ckey;
   logic                     better;
   logic [NW-1:0]            n_use;

   assign csr_ready = 1'b1;
   assign req_ready = cmd.load;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = ov_ff && rsp_ready;
   assign store_full = (cnt_ff == CW'(msf_pkg::EDGE_MAX));

   assign n_use = (vc_ff > NW'(msf_pkg::VERTEX_MAX)) ? NW'(msf_pkg::VERTEX_MAX) : vc_ff;

   msf_ram #(.WIDTH(msf_pkg::EREC_W), .DEPTH(msf_pkg::EDGE_MAX)) u_edge_ram (
      .clock   (clock),
      .wr_en   (req_fire && !store_full),
      .wr_addr (cnt_ff[EW-1:0]),
      .wr_data ({req_src_vertex, req_dest_vertex, req_edge_weight}),
      .rd_addr (sidx_ff[EW-1:0]),
      .rd_data (erec_rd)
   );

   msf_ram #(.WIDTH(VW), .DEPTH(msf_pkg::VERTEX_MAX)) u_parent_ram (
      .clock   (clock),
      .wr_en   (cmd.link),
      .wr_addr (ra_ff[AW-1:0]),
      .wr_data (rb_ff),
      .rd_addr (v_ff[AW-1:0]),
      .rd_data (prnt_rd)
   );

   assign r_src = erec_rd[msf_pkg::EREC_W-1 -: VW];
   assign r_dst = erec_rd[WW +: VW];
   assign r_w   = erec_rd[WW-1:0];
   // Offset-binary weight with the store index below it gives a stable order.
   assign ckey  = {~r_w[WW-1], r_w[WW-2:0], rdi_ff};
   assign better = (!hp_ff || (ckey > pkey_ff)) && (!hb_ff || (ckey < bkey_ff));
   assign p_val = pv_ff ? prnt_rd : v_ff;

   always_comb begin
      sts.req_fire     = req_fire;
      sts.req_last     = req_last_edge;
      sts.stop         = ({1'b0, acc_ff} + NW'(1)) >= n_use;
      sts.scan_end     = (sidx_ff == cnt_ff) && !rdp_ff;
      sts.have_best    = hb_ff;
      sts.out_of_range = ({1'b0, bsrc_ff} >= n_use) || ({1'b0, bdst_ff} >= n_use);
      sts.fnd_root     = (p_val == v_ff);
      sts.fnd_phase    = ph_ff;
      sts.roots_equal  = (ra_ff == rb_ff);
      sts.held_valid   = held_ff;
      sts.out_free     = !ov_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff   <= msf_pkg::VC_RESET;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         acc_ff  <= '0;
         rdp_ff  <= 1'b0;
         hp_ff   <= 1'b0;
         hb_ff   <= 1'b0;
         vld_ff  <= '0;
         held_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            vc_ff <= csr_vertex_count;
         end
         if (req_fire) begin
            if (store_full) begin
               ovf_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + CW'(1);
            end
         end
         if (cmd.scan_start) begin
            sidx_ff <= '0;
            rdp_ff  <= 1'b0;
            hb_ff   <= 1'b0;
         end
         if (cmd.scan_step) begin
            if (rdp_ff && better) begin
               hb_ff   <= 1'b1;
               bkey_ff <= ckey;
               bsrc_ff <= r_src;
               bdst_ff <= r_dst;
               bw_ff   <= r_w;
            end
            if (sidx_ff != cnt_ff) begin
               rdi_ff  <= sidx_ff[EW-1:0];
               rdp_ff  <= 1'b1;
               sidx_ff <= sidx_ff + CW'(1);
            end else begin
               rdp_ff <= 1'b0;
            end
         end
         if (cmd.pick) begin
            pkey_ff <= bkey_ff;
            hp_ff   <= 1'b1;
            v_ff    <= bsrc_ff;
            ph_ff   <= 1'b0;
         end
         if (cmd.find_issue) begin
            pv_ff <= vld_ff[v_ff[AW-1:0]];
         end
         if (cmd.find_check) begin
            if (p_val == v_ff) begin
               if (!ph_ff) begin
                  ra_ff <= v_ff;
                  v_ff  <= bdst_ff;
                  ph_ff <= 1'b1;
               end else begin
                  rb_ff <= v_ff;
               end
            end else begin
               v_ff <= p_val;
            end
         end
         if (cmd.link) begin
            vld_ff[ra_ff[AW-1:0]] <= 1'b1;
            acc_ff <= acc_ff + VW'(1);
         end
         if (cmd.hold_new || cmd.push_held) begin
            held_ff <= 1'b1;
            hsrc_ff <= bsrc_ff;
            hdst_ff <= bdst_ff;
            hw_ff   <= bw_ff;
         end
         if (rsp_fire) begin
            ov_ff <= 1'b0;
         end
         if (cmd.push_held) begin
            ov_ff    <= 1'b1;
            oev_ff   <= 1'b1;
            olast_ff <= 1'b0;
            oovf_ff  <= ovf_ff;
            osrc_ff  <= hsrc_ff;
            odst_ff  <= hdst_ff;
            ow_ff    <= hw_ff;
         end
         if (cmd.push_final) begin
            ov_ff    <= 1'b1;
            oev_ff   <= held_ff;
            olast_ff <= 1'b1;
            oovf_ff  <= ovf_ff;
            osrc_ff  <= held_ff ? hsrc_ff : '0;
            odst_ff  <= held_ff ? hdst_ff : '0;
            ow_ff    <= held_ff ? hw_ff : '0;
            // The graph state returns to its reset values for the next run.
            cnt_ff   <= '0;
            ovf_ff   <= 1'b0;
            acc_ff   <= '0;
            hp_ff    <= 1'b0;
            vld_ff   <= '0;
            held_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid          = ov_ff;
   assign rsp_tree_src       = osrc_ff;
   assign rsp_tree_dest      = odst_ff;
   assign rsp_tree_weight    = ow_ff;
   assign rsp_edge_valid     = oev_ff;
   assign rsp_last_result    = olast_ff;
   assign rsp_store_overflow = oovf_ff;

endmodule

[src/minimum_spanning_forest_unit.sv]
// Top level of the minimum spanning forest unit: controller plus datapath.
//
// Edges are loaded one transaction per cycle into a 256-entry edge store; the
// transaction with last_edge set starts a run and the input stalls until the
// run's final result has been placed in the output register. The run visits
// the edges in stable weight order by selection: each pass reads the whole
// edge store through its single read port, and a run takes up to E + 1 passes
// for E stored edges, plus the union-find walks. Each find walks the parent
// store one link at a time through its registered read. Accepted edges are
// delivered in order with last_result on the final one; an empty tree gives
// one result with edge_valid low. The vertex_count register takes a write in
// any cycle and should only be written while no run is in progress. No
// clearing pass is needed after reset: parent links carry per-vertex valid
// bits.
module minimum_spanning_forest_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [msf_pkg::VC_W-1:0]           csr_vertex_count,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [msf_pkg::VTX_W-1:0]          req_src_vertex,
   input  logic [msf_pkg::VTX_W-1:0]          req_dest_vertex,
   input  logic signed [msf_pkg::WEIGHT_W-1:0] req_edge_weight,
   input  logic                               req_last_edge,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [msf_pkg::VTX_W-1:0]          rsp_tree_src,
   output logic [msf_pkg::VTX_W-1:0]          rsp_tree_dest,
   output logic signed [msf_pkg::WEIGHT_W-1:0] rsp_tree_weight,
   output logic                               rsp_edge_valid,
   output logic                               rsp_last_result,
   output logic                               rsp_store_overflow
);

   // Commands flow from the controller, status flows back.
   msf_pkg::ctrl_cmd_type cmd;
   msf_pkg::ctrl_sts_type sts;

   msf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   msf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_vertex_count   (csr_vertex_count),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_src_vertex     (req_src_vertex),
      .req_dest_vertex    (req_dest_vertex),
      .req_edge_weight    (req_edge_weight),
      .req_last_edge      (req_last_edge),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_tree_src       (rsp_tree_src),
      .rsp_tree_dest      (rsp_tree_dest),
      .rsp_tree_weight    (rsp_tree_weight),
      .rsp_edge_valid     (rsp_edge_valid),
      .rsp_last_result    (rsp_last_result),
      .rsp_store_overflow (rsp_store_overflow)
   );

endmodule

[verif/minimum_spanning_forest_unit_test.sv]
// Self-checking testbench for the minimum spanning forest unit.
`timescale 1ns / 1ps

module minimum_spanning_forest_unit_test;

   // Expected tree edge, one per result transaction.
   typedef struct packed {
      logic [msf_pkg::VTX_W-1:0]           src;
      logic [msf_pkg::VTX_W-1:0]           dest;
      logic signed [msf_pkg::WEIGHT_W-1:0] weight;
      logic                                edge_valid;
      logic                                last_result;
      logic                                overflow;
   } tree_edge_type;

   // The scoreboard keeps its own Kruskal forest builder. Each accepted edge
   // transaction is stored while there is room; the last one sorts the stored
   // edges stably by signed weight, runs union-find and queues the tree edges.
   class forest_scoreboard;
      logic [msf_pkg::VTX_W-1:0]           edge_src[msf_pkg::EDGE_MAX];
      logic [msf_pkg::VTX_W-1:0]           edge_dest[msf_pkg::EDGE_MAX];
      logic signed [msf_pkg::WEIGHT_W-1:0] edge_weight[msf_pkg::EDGE_MAX];
      int                                  edge_count;
      bit                                  dropped;
      int                                  vertices;
      int                                  parent[msf_pkg::VERTEX_MAX];
      int                                  rank_of[msf_pkg::VERTEX_MAX];
      tree_edge_type                       pending_edges[$];
      int                                  errors;
      int                                  results;
      int                                  graphs;
      int                                  overflow_graphs;

      function new();
         vertices = msf_pkg::VC_RESET;
         edge_count = 0;
         dropped = 0;
         errors = 0;
         results = 0;
         graphs = 0;
         overflow_graphs = 0;
      endfunction

      function void set_vertex_count(int value);
         vertices = value;
      endfunction

      function int root_of(int v);
         int root;
         int next;
         root = v;
         while (parent[root] != root) root = parent[root];
         while (parent[v] != root) begin
            next = parent[v];
            parent[v] = root;
            v = next;
         end
         return root;
      endfunction

      function void build_forest();
         int order[msf_pkg::EDGE_MAX];
         int n, i, j, cur, ra, rb, accepted;
         tree_edge_type t;
         n = (vertices > msf_pkg::VERTEX_MAX) ? msf_pkg::VERTEX_MAX : vertices;
         for (i = 0; i < msf_pkg::VERTEX_MAX; i++) begin
            parent[i] = i;
            rank_of[i] = 0;
         end
         // Stable insertion sort on signed weight.
         for (i = 0; i < edge_count; i++) begin
            cur = i;
            j = i;
            while (j > 0 && edge_weight[order[j-1]] > edge_weight[cur]) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = cur;
         end
         accepted = 0;
         for (i = 0; i < edge_count && accepted + 1 < n; i++) begin
            cur = order[i];
            if (edge_src[cur] >= n || edge_dest[cur] >= n) continue;
            ra = root_of(edge_src[cur]);
            rb = root_of(edge_dest[cur]);
            if (ra == rb) continue;
            if (rank_of[ra] < rank_of[rb]) parent[ra] = rb;
            else if (rank_of[ra] > rank_of[rb]) parent[rb] = ra;
            else begin
               parent[rb] = ra;
               rank_of[ra] = (rank_of[ra] + 1) % 8;
            end
            accepted++;
            t = '{edge_src[cur], edge_dest[cur], edge_weight[cur], 1'b1, 1'b0, dropped};
            pending_edges = {pending_edges, t};
         end
         if (accepted == 0) begin
            t = '{'0, '0, '0, 1'b0, 1'b1, dropped};
            pending_edges = {pending_edges, t};
         end else begin
            pending_edges[pending_edges.size()-1].last_result = 1'b1;
         end
         graphs++;
         if (dropped) overflow_graphs++;
         edge_count = 0;
         dropped = 0;
      endfunction

      function void note_edge(logic [msf_pkg::VTX_W-1:0] src,
                              logic [msf_pkg::VTX_W-1:0] dest,
                              logic signed [msf_pkg::WEIGHT_W-1:0] weight, logic last);
         if (edge_count < msf_pkg::EDGE_MAX) begin
            edge_src[edge_count] = src;
            edge_dest[edge_count] = dest;
            edge_weight[edge_count] = weight;
            edge_count++;
         end else begin
            dropped = 1;
         end
         if (last) build_forest();
      endfunction

      function void check_result(tree_edge_type got);
         tree_edge_type exp_edge;
         results++;
         if (pending_edges.size() == 0) begin
            $error("unexpected result transaction: src %0d dest %0d weight %0d",
                   got.src, got.dest, got.weight);
            errors++;
            return;
         end
         exp_edge = pending_edges.pop_front();
         if (got.src !== exp_edge.src) begin
            $error("tree_src: expected %0d, got %0d", exp_edge.src, got.src);
            errors++;
         end
         if (got.dest !== exp_edge.dest) begin
            $error("tree_dest: expected %0d, got %0d", exp_edge.dest, got.dest);
            errors++;
         end
         if (got.weight !== exp_edge.weight) begin
            $error("tree_weight: expected %0d, got %0d", exp_edge.weight, got.weight);
            errors++;
         end
         if (got.edge_valid !== exp_edge.edge_valid) begin
            $error("edge_valid: expected %0d, got %0d", exp_edge.edge_valid,
                   got.edge_valid);
            errors++;
         end
         if (got.last_result !== exp_edge.last_result) begin
            $error("last_result: expected %0d, got %0d", exp_edge.last_result,
                   got.last_result);
            errors++;
         end
         if (got.overflow !== exp_edge.overflow) begin
            $error("store_overflow: expected %0d, got %0d", exp_edge.overflow,
                   got.overflow);
            errors++;
         end
      endfunction
   endclass

   // The watchdog limit must cover a whole run over a full store, in which no
   // transaction may be accepted, union-find walks included.
   localparam int STALL_LIMIT = 400000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [msf_pkg::VC_W-1:0]            csr_vertex_count = '0;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [msf_pkg::VTX_W-1:0]           req_src_vertex = '0;
   logic [msf_pkg::VTX_W-1:0]           req_dest_vertex = '0;
   logic signed [msf_pkg::WEIGHT_W-1:0] req_edge_weight = '0;
   logic                                req_last_edge = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [msf_pkg::VTX_W-1:0]           rsp_tree_src;
   logic [msf_pkg::VTX_W-1:0]           rsp_tree_dest;
   logic signed [msf_pkg::WEIGHT_W-1:0] rsp_tree_weight;
   logic                                rsp_edge_valid;
   logic                                rsp_last_result;
   logic                                rsp_store_overflow;

   forest_scoreboard forest = new();
   bit idling_enabled = 1'b1;
   int quiet_cycles = 0;
   int edges_sent = 0;
   int rsp_stall_left = 0;

   always #6 clock = ~clock;

   minimum_spanning_forest_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_vertex_count   (csr_vertex_count),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_src_vertex     (req_src_vertex),
      .req_dest_vertex    (req_dest_vertex),
      .req_edge_weight    (req_edge_weight),
      .req_last_edge      (req_last_edge),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_tree_src       (rsp_tree_src),
      .rsp_tree_dest      (rsp_tree_dest),
      .rsp_tree_weight    (rsp_tree_weight),
      .rsp_edge_valid     (rsp_edge_valid),
      .rsp_last_result    (rsp_last_result),
      .rsp_store_overflow (rsp_store_overflow)
   );

   // Monitor: every transaction is seen at the rising edge, where inputs are
   // stable because they only move on the falling edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            forest.note_edge(req_src_vertex, req_dest_vertex, req_edge_weight,
                             req_last_edge);
         if (rsp_valid && rsp_ready)
            forest.check_result('{rsp_tree_src, rsp_tree_dest, rsp_tree_weight,
                                  rsp_edge_valid, rsp_last_result,
                                  rsp_store_overflow});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Result side back-pressure: random stall bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!idling_enabled) begin
         rsp_ready <= 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Writes vertex_count; only called while no run is in progress.
   task automatic write_vertex_count(int value);
      csr_valid <= 1'b1;
      csr_vertex_count <= value[msf_pkg::VC_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      forest.set_vertex_count(value);
   endtask

   // Sends one edge transaction, with an occasional idle burst first. Called
   // and returns on a falling edge.
   task automatic send_edge(int src, int dest, int weight, bit last);
      if (idling_enabled && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_src_vertex <= src[msf_pkg::VTX_W-1:0];
      req_dest_vertex <= dest[msf_pkg::VTX_W-1:0];
      req_edge_weight <= weight[msf_pkg::WEIGHT_W-1:0];
      req_last_edge <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      edges_sent++;
   endtask

   // Waits for every queued tree edge to arrive, then lets the unit settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (forest.pending_edges.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // A random graph: endpoints mostly below span, sometimes anywhere in the
   // field; narrow weight ranges force ties so arrival order matters.
   task automatic send_random_graph(int edge_total, int span);
      int i, s, d, w;
      bit narrow;
      narrow = $urandom_range(0, 1);
      for (i = 0; i < edge_total; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            s = $urandom_range(0, 63);
            d = $urandom_range(0, 63);
         end else begin
            s = $urandom_range(0, span - 1);
            d = $urandom_range(0, span - 1);
         end
         if (narrow) w = $signed(16'($urandom_range(0, 3))) - 2;
         else w = $signed(16'($urandom()));
         send_edge(s, d, w, i == edge_total - 1);
      end
   endtask

   initial begin : stimulus
      int vc, start_count;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed graph at the reset vertex count: field extremes, a self loop,
      // equal weights kept in arrival order, and an edge closing a cycle.
      send_edge(0, 63, -32768, 0);
      send_edge(63, 0, 32767, 0);
      send_edge(5, 5, -32768, 0);
      send_edge(1, 2, 7, 0);
      send_edge(2, 1, 7, 0);
      send_edge(3, 2, 7, 0);
      send_edge(1, 3, -1, 0);
      send_edge(42, 21, 0, 1);
      wait_drained();

      // One vertex: nothing can be accepted, so the tree comes back empty.
      write_vertex_count(1);
      send_edge(0, 0, 100, 0);
      send_edge(0, 1, -5, 1);
      wait_drained();

      // Zero vertices puts every edge out of range.
      write_vertex_count(0);
      send_edge(0, 0, 1, 1);
      wait_drained();

      // A small count puts an endpoint out of range; a lone self loop too.
      write_vertex_count(4);
      send_edge(3, 4, -9, 0);
      send_edge(0, 3, 12, 0);
      send_edge(2, 2, -3, 1);
      wait_drained();

      // Counts above the vertex limit act as the limit.
      write_vertex_count(127);
      send_edge(63, 62, 3, 0);
      send_edge(62, 61, 2, 1);
      wait_drained();

      // Random graphs with a new vertex count now and then; the last part of
      // the run has no idling on either side.
      write_vertex_count(64);
      start_count = edges_sent;
      while (edges_sent - start_count < 114) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 4))
               0: vc = 1;
               1: vc = 64;
               2: vc = $urandom_range(65, 127);
               default: vc = $urandom_range(2, 16);
            endcase
            write_vertex_count(vc);
         end
         if (edges_sent - start_count > 85) idling_enabled = 1'b0;
         vc = (forest.vertices < 1) ? 1 :
              (forest.vertices > msf_pkg::VERTEX_MAX) ? msf_pkg::VERTEX_MAX :
              forest.vertices;
         send_random_graph($urandom_range(1, 12), vc);
         wait_drained();
      end

      repeat (20) @(negedge clock);
      $display("Covered %0d edge transactions in %0d graphs (%0d with overflow),",
               edges_sent, forest.graphs, forest.overflow_graphs);
      $display("checking %0d tree edge results.", forest.results);
      if (forest.errors == 0 && forest.pending_edges.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[files.f]
src/msf_pkg.sv
src/msf_ram.sv
src/msf_ctrl.sv
src/msf_datapath.sv
src/minimum_spanning_forest_unit.sv
verif/minimum_spanning_forest_unit_test.sv
